/* hdl/lpht_pkg.sv */
package lpht_pkg;

  localparam int DEF_CAPACITY   = 1024;
  localparam int DEF_KEY_BITS   = 32;
  localparam int DEF_VALUE_BITS = 32;

  localparam int LIMIT_BITS = 10;
  localparam int COUNT_BITS = 11;
  localparam logic [LIMIT_BITS-1:0] OCC_LIMIT_RESET = 10'd768;

  localparam logic [31:0] FNV_BASIS  = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME  = 32'd16777619;
  localparam logic [31:0] MARK_EMPTY = 32'd0;
  localparam logic [31:0] MARK_TOMB  = 32'd1;

  typedef enum logic [1:0] {
    ACT_GET   = 2'd0,
    ACT_PUT   = 2'd1,
    ACT_ERASE = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_HASH,
    S_FIX,
    S_MOD,
    S_PROBE_ISSUE,
    S_PROBE,
    S_CLEAR,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic hash_step;
    logic fix;
    logic mod_step;
    logic probe_start;
    logic probe_step;
    logic clear_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic hash_last;
    logic mod_done;
    logic probe_stop;
    logic clear_last;
    logic out_free;
  } status_t;

endpackage

/* hdl/linear_probe_hash_table.sv */
// Key/value table with open addressing, linear probing and tombstones. One transaction in,
// one transaction out, one item at a time. Get, put and erase run FNV-1a hashing over
// ceil(KEY_BITS/8) key bytes (one byte and one multiply per cycle), a fixup step, index
// reduction (a reciprocal multiplication and one correction when CAPACITY is not a power
// of two), a probe start, the probe itself (one read of the slot memories per cycle) and a
// final step that updates the table and presents the result, which waits while a previous
// result is stalled. A clear sweeps the hash memory one slot per cycle, and after reset the
// same sweep runs, during which in_stall is high; occupancy_limit may be written at any
// time the block is idle.
module linear_probe_hash_table #(
  parameter int CAPACITY   = lpht_pkg::DEF_CAPACITY,
  parameter int KEY_BITS   = lpht_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS = lpht_pkg::DEF_VALUE_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      action,
  input  logic [KEY_BITS-1:0]             key,
  input  logic [VALUE_BITS-1:0]           value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            hit,
  output logic [VALUE_BITS-1:0]           value_out,
  output logic                            status,
  output logic [lpht_pkg::COUNT_BITS-1:0] live_count,
  input  logic                            write_enable,
  input  logic [lpht_pkg::LIMIT_BITS-1:0] write_data
);

  import lpht_pkg::*;

  cmd_t    cmd;
  status_t st;

  lpht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .st       (st),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  lpht_dp #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .action       (action),
    .key          (key),
    .value        (value),
    .write_enable (write_enable),
    .write_data   (write_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .hit          (hit),
    .value_out    (value_out),
    .status       (status),
    .live_count   (live_count)
  );

endmodule

/* hdl/lpht_ram.sv */
module lpht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/lpht_ctrl.sv */
module lpht_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        action,
  input  lpht_pkg::status_t st,
  output lpht_pkg::cmd_t    cmd,
  output logic              in_stall
);

  import lpht_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_INIT: begin
        cmd.clear_step = 1'b1;
        if (st.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = (action == ACT_CLEAR) ? S_CLEAR : S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        if (st.hash_last) state_next = S_FIX;
      end
      S_FIX: begin
        cmd.fix    = 1'b1;
        state_next = S_MOD;
      end
      S_MOD: begin
        if (st.mod_done) state_next = S_PROBE_ISSUE;
        else cmd.mod_step = 1'b1;
      end
      S_PROBE_ISSUE: begin
        cmd.probe_start = 1'b1;
        state_next      = S_PROBE;
      end
      S_PROBE: begin
        cmd.probe_step = 1'b1;
        if (st.probe_stop) state_next = S_FINISH;
      end
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (st.clear_last) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

endmodule

/* hdl/lpht_dp.sv */
module lpht_dp #(
  parameter int CAPACITY   = lpht_pkg::DEF_CAPACITY,
  parameter int KEY_BITS   = lpht_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS = lpht_pkg::DEF_VALUE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  lpht_pkg::cmd_t                     cmd,
  output lpht_pkg::status_t                  st,
  input  logic [1:0]                         action,
  input  logic [KEY_BITS-1:0]                key,
  input  logic [VALUE_BITS-1:0]              value,
  input  logic                               write_enable,
  input  logic [lpht_pkg::LIMIT_BITS-1:0]    write_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               hit,
  output logic [VALUE_BITS-1:0]              value_out,
  output logic                               status,
  output logic [lpht_pkg::COUNT_BITS-1:0]    live_count
);

  import lpht_pkg::*;

  localparam int IW     = $clog2(CAPACITY);
  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int NBYTES = (KEY_BITS + 7) / 8;
  localparam int KB8    = NBYTES * 8;
  localparam bit POW2   = (CAPACITY & (CAPACITY - 1)) == 0;
  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
  localparam logic [IW:0]   CAP_EXT  = (IW + 1)'(CAPACITY);
  localparam logic [31:0]   CAP_W    = 32'(CAPACITY);
  localparam logic [31:0]   RECIP    = 32'((64'd1 << (31 + IW)) / 64'(CAPACITY));

  logic [1:0]            act_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [KB8-1:0]        key_sh;
  logic [2:0]            byte_cnt;
  logic [31:0]           h;
  logic [31:0]           h_mul;
  logic [31:0]           h_fix;
  logic [63:0]           recip_prod;
  logic [31:0]           quot;
  logic [31:0]           quot_cap;
  logic [31:0]           rem_wide;
  logic [IW:0]           rem;
  logic [1:0]            mod_cnt;
  logic [IW-1:0]         start_idx;
  logic [IW-1:0]         probe_addr;
  logic [IW-1:0]         eval_idx;
  logic [IW-1:0]         probe_n;
  logic [IW-1:0]         raddr;
  logic                  have_tomb;
  logic [IW-1:0]         tomb_slot;
  logic [IW-1:0]         clear_addr;
  logic                  res_found;
  logic                  res_live;
  logic                  res_empty;
  logic [IW-1:0]         res_slot;
  logic [VALUE_BITS-1:0] res_value;
  logic [CW-1:0]         live_entries;
  logic [CW-1:0]         used_slots;
  logic [CW:0]           used_inc;
  logic [LIMIT_BITS-1:0] occ_limit;
  logic [31:0]           hd;
  logic [KEY_BITS-1:0]   kd;
  logic [VALUE_BITS-1:0] vd;
  logic                  slot_vacant;
  logic                  is_tomb;
  logic                  is_match;
  logic                  is_last;
  logic                  over_limit;
  logic                  put_new;
  logic                  do_erase;
  logic                  hash_we;
  logic [IW-1:0]         hash_waddr;
  logic [31:0]           hash_wdata;

  assign h_mul      = (h ^ {24'd0, key_sh[7:0]}) * FNV_PRIME;
  assign h_fix      = (h < 32'd2) ? h + 32'd2 : h;
  assign recip_prod = 64'(h) * 64'(RECIP);
  assign quot_cap   = quot * CAP_W;
  assign rem_wide   = h - quot_cap;
  assign start_idx  = POW2 ? h[IW-1:0] : rem[IW-1:0];
  assign raddr      = cmd.probe_start ? start_idx : probe_addr;

  assign slot_vacant = (hd == MARK_EMPTY);
  assign is_tomb     = (hd == MARK_TOMB);
  assign is_match    = (hd == h) && (kd == key_r);
  assign is_last     = (probe_n == LAST_IDX);

  assign used_inc   = {1'b0, used_slots} + (CW + 1)'(1);
  assign over_limit = 32'(used_inc) > 32'(occ_limit);
  assign put_new    = (act_r == ACT_PUT) && res_found && !res_live &&
                      !(res_empty && over_limit);
  assign do_erase   = (act_r == ACT_ERASE) && res_live;

  assign st.hash_last  = (byte_cnt == 3'(NBYTES - 1));
  assign st.mod_done   = POW2 ? 1'b1 : (mod_cnt == 2'd3);
  assign st.probe_stop = slot_vacant || is_match || is_last;
  assign st.clear_last = (clear_addr == LAST_IDX);
  assign st.out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r    <= action;
      key_r    <= key;
      val_r    <= value;
      key_sh   <= KB8'(key);
      byte_cnt <= '0;
      h        <= FNV_BASIS;
    end
    if (cmd.hash_step) begin
      h        <= h_mul;
      key_sh   <= key_sh >> 8;
      byte_cnt <= byte_cnt + 3'd1;
    end
    if (cmd.fix) begin
      h       <= h_fix;
      mod_cnt <= '0;
    end
    if (cmd.mod_step) begin
      case (mod_cnt)
        2'd0: quot <= 32'(recip_prod >> (31 + IW));
        2'd1: rem <= rem_wide[IW:0];
        default: rem <= (rem >= CAP_EXT) ? rem - CAP_EXT : rem;
      endcase
      mod_cnt <= mod_cnt + 2'd1;
    end
    if (cmd.probe_start || cmd.probe_step) begin
      eval_idx   <= raddr;
      probe_addr <= (raddr == LAST_IDX) ? '0 : raddr + IW'(1);
    end
    if (cmd.probe_start) begin
      probe_n   <= '0;
      have_tomb <= 1'b0;
    end
    if (cmd.probe_step) begin
      probe_n <= probe_n + IW'(1);
      if (is_tomb && !have_tomb) begin
        have_tomb <= 1'b1;
        tomb_slot <= eval_idx;
      end
      if (slot_vacant) begin
        res_found <= 1'b1;
        res_live  <= 1'b0;
        res_empty <= !have_tomb;
        res_slot  <= have_tomb ? tomb_slot : eval_idx;
      end else if (is_match) begin
        res_found <= 1'b1;
        res_live  <= 1'b1;
        res_empty <= 1'b0;
        res_slot  <= eval_idx;
        res_value <= vd;
      end else begin
        res_found <= have_tomb || is_tomb;
        res_live  <= 1'b0;
        res_empty <= 1'b0;
        res_slot  <= have_tomb ? tomb_slot : eval_idx;
      end
    end
    if (cmd.finish) begin
      hit        <= 1'b0;
      value_out  <= '0;
      status     <= 1'b0;
      case (act_r)
        ACT_GET: begin
          hit <= res_live;
          if (res_live) value_out <= res_value;
        end
        ACT_PUT: begin
          hit    <= put_new;
          status <= !res_found || (!res_live && res_empty && over_limit);
        end
        ACT_ERASE: hit <= res_live;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      clear_addr   <= '0;
      live_entries <= '0;
      used_slots   <= '0;
      occ_limit    <= OCC_LIMIT_RESET;
      live_count   <= '0;
    end else begin
      if (write_enable) occ_limit <= write_data;
      if (cmd.clear_step) clear_addr <= st.clear_last ? '0 : clear_addr + IW'(1);
      if (cmd.finish) begin
        out_valid <= 1'b1;
        if (act_r == ACT_CLEAR) begin
          live_entries <= '0;
          used_slots   <= '0;
          live_count   <= '0;
        end else if (do_erase) begin
          live_entries <= live_entries - CW'(1);
          live_count   <= COUNT_BITS'(live_entries - CW'(1));
        end else if (put_new) begin
          live_entries <= live_entries + CW'(1);
          live_count   <= COUNT_BITS'(live_entries + CW'(1));
          if (res_empty) used_slots <= used_slots + CW'(1);
        end else begin
          live_count <= COUNT_BITS'(live_entries);
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign hash_we    = cmd.clear_step || (cmd.finish && (do_erase || put_new));
  assign hash_waddr = cmd.clear_step ? clear_addr : res_slot;
  assign hash_wdata = cmd.clear_step ? MARK_EMPTY : (do_erase ? MARK_TOMB : h);

  lpht_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_hash_ram (
    .clk   (clk),
    .we    (hash_we),
    .waddr (hash_waddr),
    .wdata (hash_wdata),
    .raddr (raddr),
    .rdata (hd)
  );

  lpht_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_key_ram (
    .clk   (clk),
    .we    (cmd.finish && put_new),
    .waddr (res_slot),
    .wdata (key_r),
    .raddr (raddr),
    .rdata (kd)
  );

  lpht_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_value_ram (
    .clk   (clk),
    .we    (cmd.finish && (act_r == ACT_PUT) && (put_new || res_live)),
    .waddr (res_slot),
    .wdata (val_r),
    .raddr (raddr),
    .rdata (vd)
  );

endmodule

/* hdl/lpht_checker.sv */
module lpht_checker #(
  parameter int VALUE_BITS = lpht_pkg::DEF_VALUE_BITS
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            hit,
  input logic [VALUE_BITS-1:0]           value_out,
  input logic                            status,
  input logic [lpht_pkg::COUNT_BITS-1:0] live_count
);

  // stalled transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(value_out) && $stable(hit) &&
    $stable(status) && $stable(live_count))
    else $error("output transaction changed while stalled");

  a_hit_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && status))
    else $error("hit and full reported together");

  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> value_out == '0)
    else $error("value_out nonzero without hit");

  // clearing pass after reset
  a_reset_busy: assert property (@(posedge clk)
    rst |=> in_stall && !out_valid)
    else $error("block not busy after reset");

endmodule

bind linear_probe_hash_table lpht_checker #(.VALUE_BITS(VALUE_BITS)) u_lpht_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .hit        (hit),
  .value_out  (value_out),
  .status     (status),
  .live_count (live_count)
);

/* tb/sv/tb_linear_probe_hash_table.sv */
`timescale 1ns / 100ps

module tb_linear_probe_hash_table;
  import lpht_pkg::*;

  localparam int SLOTS = 1024;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    action_t     act;
    logic [31:0] k;
    logic [31:0] v;
  } op_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] value_out;
    logic        status;
    logic [10:0] live_count;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] action = '0;
  logic [31:0] key = '0;
  logic [31:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic hit;
  logic [31:0] value_out;
  logic status;
  logic [10:0] live_count;
  logic write_enable = 1'b0;
  logic [9:0] write_data = '0;

  linear_probe_hash_table dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .key(key), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .hit(hit), .value_out(value_out), .status(status), .live_count(live_count),
    .write_enable(write_enable), .write_data(write_data)
  );

  logic [31:0] tbl_hash [SLOTS];
  logic [31:0] tbl_key [SLOTS];
  logic [31:0] tbl_val [SLOTS];
  int unsigned live_n;
  int unsigned used_n;
  int unsigned occ_limit;

  op_t pending_ops[$];
  reply_t expected_replies[$];
  int errors = 0;
  int unsigned in_idle_pct = 24;
  int unsigned out_idle_pct = 24;
  bit hold_output = 1'b0;
  int unsigned quiet_cycles = 0;
  logic [31:0] key_pool[$];

  initial forever #5 clk = ~clk;

  function automatic logic [31:0] fnv_hash(logic [31:0] k);
    logic [31:0] h;
    h = FNV_BASIS;
    for (int i = 0; i < 4; i++) begin
      h = (h ^ {24'd0, k[8*i +: 8]}) * FNV_PRIME;
    end
    if (h < 32'd2) h = h + 32'd2;
    return h;
  endfunction

  function automatic int find_slot(logic [31:0] k, logic [31:0] h);
    int idx;
    int tomb;
    idx = h % SLOTS;
    tomb = -1;
    for (int n = 0; n < SLOTS; n++) begin
      if (tbl_hash[idx] == MARK_EMPTY) return (tomb >= 0) ? tomb : idx;
      if (tbl_hash[idx] == MARK_TOMB) begin
        if (tomb < 0) tomb = idx;
      end else if (tbl_hash[idx] == h && tbl_key[idx] == k) begin
        return idx;
      end
      idx = (idx + 1) % SLOTS;
    end
    return tomb;
  endfunction

  function automatic reply_t apply_op(op_t o);
    reply_t r;
    logic [31:0] h;
    int s;
    bit live;
    r = '0;
    if (o.act == ACT_CLEAR) begin
      foreach (tbl_hash[i]) tbl_hash[i] = MARK_EMPTY;
      live_n = 0;
      used_n = 0;
    end else begin
      h = fnv_hash(o.k);
      s = find_slot(o.k, h);
      live = (s >= 0) && (tbl_hash[s] > MARK_TOMB);
      case (o.act)
        ACT_GET: begin
          if (live) begin
            r.hit = 1'b1;
            r.value_out = tbl_val[s];
          end
        end
        ACT_ERASE: begin
          if (live) begin
            tbl_hash[s] = MARK_TOMB;
            live_n--;
            r.hit = 1'b1;
          end
        end
        default: begin
          if (s < 0) r.status = 1'b1;
          else if (live) tbl_val[s] = o.v;
          else if (tbl_hash[s] == MARK_EMPTY && used_n + 1 > occ_limit) r.status = 1'b1;
          else begin
            if (tbl_hash[s] == MARK_EMPTY) used_n++;
            live_n++;
            tbl_hash[s] = h;
            tbl_key[s] = o.k;
            tbl_val[s] = o.v;
            r.hit = 1'b1;
          end
        end
      endcase
    end
    r.live_count = live_n[10:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic add_op(action_t a, logic [31:0] k, logic [31:0] v);
    op_t o;
    o.act = a;
    o.k = k;
    o.v = v;
    pending_ops.push_back(o);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_ops.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
        op_t o;
        o = pending_ops.pop_front();
        expected_replies.push_back(apply_op(o));
        in_valid <= 1'b1;
        action <= o.act;
        key <= o.k;
        value <= o.v;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      out_stall <= hold_output || ($urandom_range(99) < out_idle_pct);
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("unexpected transaction", 32'd0, 32'd0);
        end else begin
          reply_t e;
          e = expected_replies.pop_front();
          if (hit !== e.hit) report_mismatch("hit", 32'(hit), 32'(e.hit));
          if (value_out !== e.value_out) report_mismatch("value_out", value_out, e.value_out);
          if (status !== e.status) report_mismatch("status", 32'(status), 32'(e.status));
          if (live_count !== e.live_count)
            report_mismatch("live_count", 32'(live_count), 32'(e.live_count));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic drain();
    while (pending_ops.size() > 0 || in_valid || expected_replies.size() > 0) @(posedge clk);
    repeat (SLOTS + 50) @(posedge clk);
  endtask

  task automatic set_limit(int unsigned lim);
    @(posedge clk);
    write_enable <= 1'b1;
    write_data <= lim[9:0];
    occ_limit = lim;
    @(posedge clk);
    write_enable <= 1'b0;
  endtask

  task automatic random_phase(int n, int pool_max);
    for (int i = 0; i < n; i++) begin
      int unsigned sel;
      logic [31:0] k;
      sel = $urandom_range(99);
      if (key_pool.size() > 0 && $urandom_range(3) != 0)
        k = key_pool[$urandom_range(key_pool.size() - 1)];
      else begin
        k = $urandom();
        if (key_pool.size() < pool_max) key_pool.push_back(k);
      end
      if (sel < 40) add_op(ACT_PUT, k, $urandom());
      else if (sel < 70) add_op(ACT_GET, k, $urandom());
      else if (sel < 99) add_op(ACT_ERASE, k, $urandom());
      else add_op(ACT_CLEAR, $urandom(), $urandom());
    end
  endtask

  initial begin
    foreach (tbl_hash[i]) begin
      tbl_hash[i] = MARK_EMPTY;
      tbl_key[i] = '0;
      tbl_val[i] = '0;
    end
    live_n = 0;
    used_n = 0;
    occ_limit = OCC_LIMIT_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed
    add_op(ACT_GET, 32'h0, 32'h0);
    add_op(ACT_PUT, 32'h0, 32'hFFFF_FFFF);
    add_op(ACT_PUT, 32'hFFFF_FFFF, 32'h0);
    add_op(ACT_GET, 32'h0, 32'h0);
    add_op(ACT_GET, 32'hFFFF_FFFF, 32'h0);
    add_op(ACT_PUT, 32'h0, 32'hA5A5_5A5A);
    add_op(ACT_GET, 32'h0, 32'h0);
    add_op(ACT_ERASE, 32'h0, 32'h0);
    add_op(ACT_ERASE, 32'h0, 32'h0);
    add_op(ACT_GET, 32'h0, 32'h0);
    add_op(ACT_PUT, 32'h0, 32'h1234_5678);
    add_op(ACT_PUT, 32'h1, 32'h5555_5555);
    add_op(ACT_PUT, 32'h8000_0000, 32'hAAAA_AAAA);
    add_op(ACT_CLEAR, 32'h0, 32'h0);
    add_op(ACT_GET, 32'h1, 32'h0);
    drain();

    // tiny limit: refusals, tombstone reuse past the limit
    set_limit(2);
    add_op(ACT_PUT, 32'h10, 32'h1);
    add_op(ACT_PUT, 32'h20, 32'h2);
    add_op(ACT_PUT, 32'h30, 32'h3);
    add_op(ACT_ERASE, 32'h10, 32'h0);
    add_op(ACT_PUT, 32'h30, 32'h3);
    add_op(ACT_GET, 32'h30, 32'h0);
    drain();
    set_limit(0);
    add_op(ACT_CLEAR, 32'h0, 32'h0);
    add_op(ACT_PUT, 32'h40, 32'h4);
    drain();

    // random, no idling, full limit
    in_idle_pct = 0;
    out_idle_pct = 0;
    set_limit(1023);
    add_op(ACT_CLEAR, 32'h0, 32'h0);
    for (int i = 0; i < 60; i++) add_op(ACT_PUT, $urandom(), $urandom());
    random_phase(150, 40);
    drain();

    // receiver holds off while sender keeps offering
    in_idle_pct = 24;
    out_idle_pct = 24;
    set_limit(768);
    key_pool.delete();
    random_phase(40, 20);
    hold_output = 1'b1;
    repeat (300) @(posedge clk);
    hold_output = 1'b0;
    drain();

    set_limit(1);
    key_pool.delete();
    random_phase(200, 8);
    drain();
    set_limit(16);
    key_pool.delete();
    random_phase(400, 24);
    drain();
    set_limit(768);
    key_pool.delete();
    random_phase(400, 200);
    drain();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
